// ----- hw/rtl/rip_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rip_pkg;

    // string length limit; positions saturate one below it
    localparam int MAX_LEN = 4096;
    localparam int POS_W = 12;
    localparam int LEN_W = 13;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN - 1);

    localparam logic [5:0] BASE_DEC = 6'd10;
    localparam logic [5:0] BASE_HEX = 6'd16;
    localparam logic [5:0] BASE_BIN = 6'd2;

    // result status codes, also used as the stored error code
    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_DOMAIN = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // digit value that no base accepts
    localparam logic [6:0] DIGIT_NONE = 7'd99;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_COUNT,
        PH_STOP
    } phase_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
        logic       last;
        logic [5:0] base;
    } char_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [63:0]      value;
        logic [POS_W-1:0] span_start;
        logic [LEN_W-1:0] span_length;
        logic [5:0]       base_used;
    } result_t;

    typedef struct packed {
        logic [63:0]      accum;
        logic [5:0]       cur_base;
        phase_t           phase;
        logic             zero_pending;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] first_digit_pos;
        logic [POS_W-1:0] last_digit_pos;
        logic [1:0]       err_code;
    } state_t;

    localparam state_t STATE_RESET = '{
        accum:           64'd0,
        cur_base:        BASE_DEC,
        phase:           PH_LEAD,
        zero_pending:    1'b0,
        position:        '0,
        first_digit_pos: '0,
        last_digit_pos:  '0,
        err_code:        STATUS_OK
    };

    // case-insensitive digit value, DIGIT_NONE for anything else
    function automatic logic [6:0] digit_of(input logic [7:0] c);
        logic [6:0] v;
        v = DIGIT_NONE;
        if (c >= "0" && c <= "9")
        begin
            v = 7'(c - "0");
        end
        else if (c >= "a" && c <= "z")
        begin
            v = 7'(c - "a") + 7'd10;
        end
        else if (c >= "A" && c <= "Z")
        begin
            v = 7'(c - "A") + 7'd10;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rip_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface rip_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/rip_in_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rip_in_reg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    rip_stream_if.sink          chars,
    input  wire logic           take,
    output logic                item_valid,
    output rip_pkg::char_t      item
);

    logic           valid_reg;
    logic           valid_next;
    rip_pkg::char_t item_reg;

    // stage is free when empty or when its item moves on this cycle
    assign chars.ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (chars.valid && chars.ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            item_reg <= chars.data;
        end
    end

    assign item_valid = valid_reg;
    assign item = item_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/rip_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rip_step #(
    parameter int MAX_BASE = 36
) (
    input  wire rip_pkg::state_t  cur,
    input  wire rip_pkg::char_t   item,
    output rip_pkg::state_t       nxt,
    output rip_pkg::result_t      res
);

    localparam logic [5:0] MaxBase = 6'(MAX_BASE);

    rip_pkg::state_t             s;
    logic [rip_pkg::POS_W-1:0]   idx;
    logic [rip_pkg::POS_W-1:0]   idx_inc;
    logic [6:0]                  v;
    logic                        check_digit;
    logic                        is_x;
    logic                        is_b;
    logic [69:0]                 mul;
    logic [70:0]                 sum;
    logic [rip_pkg::LEN_W-1:0]   span_len;

    always_comb
    begin
        // a first character restarts the string with the sampled base
        s = cur;
        if (item.first)
        begin
            s = rip_pkg::STATE_RESET;
            s.cur_base = item.base;
            if (item.base < 6'd2 || item.base > MaxBase)
            begin
                s.err_code = rip_pkg::STATUS_DOMAIN;
                s.phase = rip_pkg::PH_STOP;
            end
        end

        idx = s.position;
        idx_inc = (idx == rip_pkg::POS_MAX) ? rip_pkg::POS_MAX : idx + 1'b1;
        v = rip_pkg::digit_of(item.ch);
        is_x = (item.ch == "x" || item.ch == "X") &&
               (s.cur_base == rip_pkg::BASE_DEC || s.cur_base == rip_pkg::BASE_HEX);
        is_b = (item.ch == "b" || item.ch == "B") &&
               (s.cur_base == rip_pkg::BASE_DEC || s.cur_base == rip_pkg::BASE_BIN);
        check_digit = 1'b0;

        if (s.phase != rip_pkg::PH_STOP)
        begin
            check_digit = 1'b1;
            if (s.phase == rip_pkg::PH_LEAD)
            begin
                if (s.zero_pending)
                begin
                    s.zero_pending = 1'b0;
                    if (is_x || is_b)
                    begin
                        // prefix: span opens just past it, empty so far
                        s.cur_base = is_x ? rip_pkg::BASE_HEX : rip_pkg::BASE_BIN;
                        s.first_digit_pos = idx_inc;
                        s.last_digit_pos = idx_inc - 1'b1;
                        s.phase = rip_pkg::PH_COUNT;
                        check_digit = 1'b0;
                    end
                    else
                    begin
                        // held zero becomes a digit; accum stays zero
                        s.last_digit_pos = s.first_digit_pos;
                        s.phase = rip_pkg::PH_COUNT;
                    end
                end
                else if (item.ch == " " || item.ch == "\t")
                begin
                    check_digit = 1'b0;
                end
                else if (item.ch == "0" && !item.last &&
                         (s.cur_base == rip_pkg::BASE_DEC ||
                          s.cur_base == rip_pkg::BASE_HEX ||
                          s.cur_base == rip_pkg::BASE_BIN))
                begin
                    // hold the zero to look at the next character
                    s.zero_pending = 1'b1;
                    s.first_digit_pos = idx;
                    check_digit = 1'b0;
                end
            end
        end

        // multiply-add with exact overflow from the carry-out bits
        mul = s.accum * s.cur_base;
        sum = {1'b0, mul} + 71'(v);

        if (check_digit)
        begin
            if (v >= {1'b0, s.cur_base})
            begin
                s.err_code = (s.phase == rip_pkg::PH_LEAD) ?
                             rip_pkg::STATUS_DOMAIN : rip_pkg::STATUS_OK;
                s.phase = rip_pkg::PH_STOP;
            end
            else
            begin
                if (s.phase == rip_pkg::PH_LEAD)
                begin
                    s.first_digit_pos = idx;
                    s.phase = rip_pkg::PH_COUNT;
                end
                s.last_digit_pos = idx;
                s.accum = sum[63:0];
                if (sum[70:64] != 7'd0)
                begin
                    s.err_code = rip_pkg::STATUS_RANGE;
                    s.phase = rip_pkg::PH_STOP;
                end
            end
        end

        s.position = idx_inc;

        // result fields, valid when the item is the last one
        span_len = {1'b0, s.last_digit_pos} + 1'b1 - {1'b0, s.first_digit_pos};
        if (s.phase == rip_pkg::PH_LEAD ||
            (s.phase == rip_pkg::PH_STOP && s.err_code == rip_pkg::STATUS_DOMAIN))
        begin
            res.status = rip_pkg::STATUS_DOMAIN;
            res.value = 64'd0;
            res.span_start = '0;
            res.span_length = '0;
        end
        else
        begin
            res.status = (s.phase == rip_pkg::PH_STOP) ? s.err_code : rip_pkg::STATUS_OK;
            res.value = s.accum;
            res.span_start = s.first_digit_pos;
            res.span_length = span_len;
        end
        res.base_used = s.cur_base;

        // the block starts over after every result
        nxt = item.last ? rip_pkg::STATE_RESET : s;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/radix_integer_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

// path: a last character goes through the input register, then the result register
// throughput: one character per cycle, limited by the 64x6 multiply-add loop on accum
// a waiting result does not stop the stream: only a last character waits on it
// reset: asynchronous, active low; clears the stages and the parse state (base ten)

module radix_integer_parser #(
    parameter int MAX_BASE = 36
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    rip_stream_if.sink    chars,
    rip_stream_if.source  result
);

    logic              item_valid;
    rip_pkg::char_t    item;
    logic              advance;
    rip_pkg::state_t   state_reg;
    rip_pkg::state_t   state_next;
    rip_pkg::result_t  step_res;
    logic              out_valid_reg;
    logic              out_valid_next;
    rip_pkg::result_t  out_data_reg;

    // input register
    rip_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // one character of parse work
    rip_step #(
        .MAX_BASE (MAX_BASE)
    ) u_step (
        .cur  (state_reg),
        .item (item),
        .nxt  (state_next),
        .res  (step_res)
    );

    // only a last character needs room in the result register
    assign advance = item_valid &&
                     (!item.last || !out_valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rip_pkg::STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && item.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item.last)
        begin
            out_data_reg <= step_res;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data = out_data_reg;

`ifndef SYNTHESIS
    // a domain error never carries a value or a span
    a_domain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.status == rip_pkg::STATUS_DOMAIN
        |-> result.data.value == 64'd0 && result.data.span_length == '0)
        else $error("domain error result with value or span");

    // after a string ends the parse state is back at its start
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.last
        |=> state_reg.phase == rip_pkg::PH_LEAD && state_reg.accum == 64'd0 &&
            state_reg.position == '0)
        else $error("parse state not cleared after last item");

    // the input stage only stalls while it holds a last item blocked by a held result
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !chars.ready |-> item_valid && item.last && out_valid_reg)
        else $error("input stalled without a blocked last item");

    // a held result is not overwritten
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid && $stable(result.data))
        else $error("pending result lost");
`endif

endmodule

`default_nettype wire
